### design/lrc_pkg.sv
package lrc_pkg;

  // Sizes and field widths
  localparam int MAX_COLS       = 1024;
  localparam int MAX_ROWS       = 1024;
  localparam int PIXEL_BITS     = 16;
  localparam int COEF_BITS      = 16;
  localparam int ACC_BITS       = 32;
  localparam int POS_BITS       = 10;
  localparam int SIZE_BITS      = 11;
  localparam int ADDR_BITS      = $clog2(MAX_COLS);
  localparam int KERNEL_BITS    = 3 * COEF_BITS;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 48;
  localparam int LINE_BITS      = 2 * PIXEL_BITS;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_IMAGE_ROWS    = 3'd0,
    CFG_IMAGE_COLS    = 3'd1,
    CFG_KERNEL_TOP    = 3'd2,
    CFG_KERNEL_MID    = 3'd3,
    CFG_KERNEL_BOTTOM = 3'd4
  } cfg_index_t;

  // Input request
  typedef struct packed {
    logic signed [PIXEL_BITS-1:0] pixel;
    logic                         frame_start;
  } pix_item_t;

  // Output request
  typedef struct packed {
    logic [POS_BITS-1:0]        centre_row;
    logic [POS_BITS-1:0]        centre_col;
    logic signed [ACC_BITS-1:0] conv_value;
  } res_item_t;

  // Pipeline stage control: valid plus centre coordinates
  typedef struct packed {
    logic                valid;
    logic [POS_BITS-1:0] row;
    logic [POS_BITS-1:0] col;
  } lrc_stage_t;

  // Line store update request for the window stage
  typedef struct packed {
    logic                  valid;
    logic [ADDR_BITS-1:0]  addr;
    logic [PIXEL_BITS-1:0] pixel;
  } lrc_line_req_t;

  typedef logic [2:0][2:0][PIXEL_BITS-1:0] window_t;
  typedef logic [2:0][2:0][COEF_BITS-1:0]  coef_t;
  typedef logic [2:0][2:0][ACC_BITS-1:0]   prod_t;
  typedef logic [2:0][ACC_BITS-1:0]        row_sum_t;

endpackage

### design/lrc_ram.sv
module lrc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/lrc_line_window.sv
module lrc_line_window (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  logic [lrc_pkg::ADDR_BITS-1:0]        rd_addr,
  input  lrc_pkg::lrc_line_req_t               req,
  output lrc_pkg::window_t                     win
);

  localparam int PB = lrc_pkg::PIXEL_BITS;

  logic                           we;
  logic [lrc_pkg::LINE_BITS-1:0]  wdata;
  logic [lrc_pkg::LINE_BITS-1:0]  rdata;
  logic                           fwd_hit;
  logic [lrc_pkg::LINE_BITS-1:0]  fwd_data;
  logic [lrc_pkg::LINE_BITS-1:0]  line_eff;
  logic [PB-1:0]                  upper_eff;
  logic [PB-1:0]                  lower_eff;
  lrc_pkg::window_t               win_next;

  // Both line stores share one RAM word: {upper, lower}
  lrc_ram #(
    .WIDTH(lrc_pkg::LINE_BITS),
    .DEPTH(lrc_pkg::MAX_COLS)
  ) u_line_ram (
    .clk  (clk),
    .we   (we),
    .waddr(req.addr),
    .wdata(wdata),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  // Bypass a write that landed in the same cycle as the read
  assign line_eff  = fwd_hit ? fwd_data : rdata;
  assign upper_eff = line_eff[lrc_pkg::LINE_BITS-1:PB];
  assign lower_eff = line_eff[PB-1:0];

  assign we    = adv && req.valid;
  assign wdata = {lower_eff, req.pixel};

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= we && (req.addr == rd_addr);
    end
    fwd_data <= wdata;
  end

  // Shift the window one column and bring in the new column
  always_comb begin
    win_next = win;
    for (int k = 0; k < 3; k++) begin
      win_next[k][0] = win[k][1];
      win_next[k][1] = win[k][2];
    end
    win_next[0][2] = upper_eff;
    win_next[1][2] = lower_eff;
    win_next[2][2] = req.pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (we) begin
      win <= win_next;
    end
  end

endmodule

### design/lrc_mac.sv
module lrc_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  lrc_pkg::lrc_stage_t                  stage_in,
  input  lrc_pkg::window_t                     win,
  input  lrc_pkg::coef_t                       coef,
  output lrc_pkg::lrc_stage_t                  stage_out,
  output logic signed [lrc_pkg::ACC_BITS-1:0]  sum
);

  lrc_pkg::prod_t      prod;
  lrc_pkg::prod_t      prod_q;
  lrc_pkg::row_sum_t   row_sum;
  lrc_pkg::row_sum_t   row_sum_q;
  lrc_pkg::lrc_stage_t stage_mid;

  // Nine products, kept modulo 2^32
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        prod[k][j] = lrc_pkg::ACC_BITS'($signed(win[k][j]) * $signed(coef[k][j]));
      end
    end
  end

  // Per-row sums of the registered products
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      row_sum[k] = prod_q[k][0] + prod_q[k][1] + prod_q[k][2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_mid.valid <= 1'b0;
      stage_out.valid <= 1'b0;
    end else if (adv) begin
      stage_mid.valid <= stage_in.valid;
      stage_out.valid <= stage_mid.valid;
    end
    if (adv) begin
      stage_mid.row <= stage_in.row;
      stage_mid.col <= stage_in.col;
      stage_out.row <= stage_mid.row;
      stage_out.col <= stage_mid.col;
      prod_q        <= prod;
      row_sum_q     <= row_sum;
    end
  end

  // Final add of the three row sums
  assign sum = $signed(row_sum_q[0] + row_sum_q[1] + row_sum_q[2]);

endmodule

### design/leftover_region_conv3x3_core.sv
// Leftover-region 3x3 convolution core.
// Pixels enter on the pix channel (valid/ready) in raster order; frame_start
// on a pixel sets the position to row 0, column 0 before that pixel is used.
// A result request on the res channel carries the window centre (row, col)
// and the 32-bit wrapped weighted sum, and appears only for centres in the
// region below the last full 4x4 block row or right of the last full block
// column. Most pixels give no result.
// Configuration goes through cfg_we/cfg_index/cfg_data, one register per
// cycle, while the stream is idle.
// Throughput: one pixel per cycle unless the output stalls. The line
// stores sit in one RAM that is read when a pixel is accepted and written
// back from the stage 1 register, with a bypass for back-to-back accesses
// to the same column. After its last window pixel is accepted, a result
// passes the RAM read, window update, products, row sums and output register.
// When res_ready is low and a result is held, the pipeline stops only once
// the next result reaches the last pipeline stage; pix_ready then drops.
// Reset (synchronous rst) clears the position, the window, the pipeline
// valids and the registers to 64 x 64 with zero kernels. Line stores are
// not cleared; they hold valid data once a line has passed.
module leftover_region_conv3x3_core (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     pix_valid,
  output logic                                     pix_ready,
  input  lrc_pkg::pix_item_t                       pix,
  output logic                                     res_valid,
  input  logic                                     res_ready,
  output lrc_pkg::res_item_t                       res,
  input  logic                                     cfg_we,
  input  logic [lrc_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
  input  logic [lrc_pkg::CFG_DATA_BITS-1:0]        cfg_data
);

  localparam int PB = lrc_pkg::POS_BITS;
  localparam int SB = lrc_pkg::SIZE_BITS;
  localparam int CB = lrc_pkg::COEF_BITS;

  // Configuration registers
  logic [SB-1:0]                   image_rows;
  logic [SB-1:0]                   image_cols;
  logic [lrc_pkg::KERNEL_BITS-1:0] kernel_top;
  logic [lrc_pkg::KERNEL_BITS-1:0] kernel_mid;
  logic [lrc_pkg::KERNEL_BITS-1:0] kernel_bottom;

  logic [SB-1:0] rows_eff;
  logic [SB-1:0] cols_eff;
  logic [SB-1:0] rows_m2;
  logic [SB-1:0] cols_m2;
  logic [SB-1:0] row_thr;
  logic [SB-1:0] col_thr;

  logic [PB-1:0] row_position;
  logic [PB-1:0] col_position;
  logic [PB-1:0] row_cur;
  logic [PB-1:0] col_cur;
  logic [PB-1:0] row_position_next;
  logic [PB-1:0] col_position_next;
  logic [SB-1:0] row_cur_x;
  logic [SB-1:0] col_cur_x;
  logic          emit_cur;

  logic                                  adv;
  logic                                  accept;
  logic [lrc_pkg::ADDR_BITS-1:0]         rd_addr;
  lrc_pkg::lrc_line_req_t                s1_req;
  lrc_pkg::lrc_stage_t                   s1_stage;
  lrc_pkg::lrc_stage_t                   s2_stage;
  lrc_pkg::lrc_stage_t                   s4_stage;
  lrc_pkg::window_t                      win;
  lrc_pkg::coef_t                        coef;
  logic signed [lrc_pkg::ACC_BITS-1:0]   sum;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows    <= SB'(64);
      image_cols    <= SB'(64);
      kernel_top    <= '0;
      kernel_mid    <= '0;
      kernel_bottom <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lrc_pkg::CFG_IMAGE_ROWS:    image_rows    <= cfg_data[SB-1:0];
        lrc_pkg::CFG_IMAGE_COLS:    image_cols    <= cfg_data[SB-1:0];
        lrc_pkg::CFG_KERNEL_TOP:    kernel_top    <= cfg_data[lrc_pkg::KERNEL_BITS-1:0];
        lrc_pkg::CFG_KERNEL_MID:    kernel_mid    <= cfg_data[lrc_pkg::KERNEL_BITS-1:0];
        lrc_pkg::CFG_KERNEL_BOTTOM: kernel_bottom <= cfg_data[lrc_pkg::KERNEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamped frame size and start of the leftover region (centre + 1)
  always_comb begin
    rows_eff = image_rows;
    if (image_rows < SB'(3)) begin
      rows_eff = SB'(3);
    end else if (image_rows > SB'(lrc_pkg::MAX_ROWS)) begin
      rows_eff = SB'(lrc_pkg::MAX_ROWS);
    end
    cols_eff = image_cols;
    if (image_cols < SB'(3)) begin
      cols_eff = SB'(3);
    end else if (image_cols > SB'(lrc_pkg::MAX_COLS)) begin
      cols_eff = SB'(lrc_pkg::MAX_COLS);
    end
  end

  assign rows_m2 = rows_eff - SB'(2);
  assign cols_m2 = cols_eff - SB'(2);
  assign row_thr = {rows_m2[SB-1:2], 2'b00} + SB'(2);
  assign col_thr = {cols_m2[SB-1:2], 2'b00} + SB'(2);

  // Kernel coefficients, column 0 in the low bits
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      coef[0][j] = kernel_top[CB*j +: CB];
      coef[1][j] = kernel_mid[CB*j +: CB];
      coef[2][j] = kernel_bottom[CB*j +: CB];
    end
  end

  // Pipeline advances unless a result would land on a held output
  assign adv       = !res_valid || res_ready || !s4_stage.valid;
  assign pix_ready = adv;
  assign accept    = pix_valid && adv;

  // Position of the incoming pixel
  assign row_cur   = (pix_valid && pix.frame_start) ? '0 : row_position;
  assign col_cur   = (pix_valid && pix.frame_start) ? '0 : col_position;
  assign row_cur_x = {1'b0, row_cur};
  assign col_cur_x = {1'b0, col_cur};

  assign emit_cur = (row_cur_x >= SB'(2)) && (col_cur_x >= SB'(2)) &&
                    (row_cur_x < rows_eff) && (col_cur_x < cols_eff) &&
                    ((row_cur_x >= row_thr) || (col_cur_x >= col_thr));

  always_comb begin
    if (col_cur_x + SB'(1) >= cols_eff) begin
      col_position_next = '0;
      row_position_next = (row_cur_x + SB'(1) >= rows_eff) ? '0 : row_cur + PB'(1);
    end else begin
      col_position_next = col_cur + PB'(1);
      row_position_next = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_position <= '0;
      col_position <= '0;
    end else if (accept) begin
      row_position <= row_position_next;
      col_position <= col_position_next;
    end
  end

  // Line read at acceptance; re-read the held column while stalled
  assign rd_addr = adv ? col_cur[lrc_pkg::ADDR_BITS-1:0] : s1_req.addr;

  // Stage 1: RAM data arrives, window update and write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_req.valid   <= 1'b0;
      s1_stage.valid <= 1'b0;
      s2_stage.valid <= 1'b0;
    end else if (adv) begin
      s1_req.valid   <= accept;
      s1_stage.valid <= accept && emit_cur;
      s2_stage.valid <= s1_req.valid && s1_stage.valid;
    end
    if (adv) begin
      s1_req.addr   <= col_cur[lrc_pkg::ADDR_BITS-1:0];
      s1_req.pixel  <= pix.pixel;
      s1_stage.row  <= row_cur - PB'(1);
      s1_stage.col  <= col_cur - PB'(1);
      s2_stage.row  <= s1_stage.row;
      s2_stage.col  <= s1_stage.col;
    end
  end

  lrc_line_window u_line_window (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .rd_addr(rd_addr),
    .req    (s1_req),
    .win    (win)
  );

  lrc_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .stage_in (s2_stage),
    .win      (win),
    .coef     (coef),
    .stage_out(s4_stage),
    .sum      (sum)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv && s4_stage.valid) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
    if (adv && s4_stage.valid) begin
      res.centre_row <= s4_stage.row;
      res.centre_col <= s4_stage.col;
      res.conv_value <= sum;
    end
  end

  // Assertions
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> pix_ready)
    else $error("pixel request refused with an empty output");

  a_centre_interior: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.centre_row != '0) && (res.centre_col != '0))
    else $error("result centre on the image border");

  a_stall_holds_line: assert property (@(posedge clk) disable iff (rst)
    (s1_req.valid && !adv) |=> s1_req.valid && $stable(s1_req.addr))
    else $error("line store stage lost its pixel during a stall");

  a_result_from_pipe: assert property (@(posedge clk) disable iff (rst)
    (!res_valid && !s4_stage.valid) |=> !res_valid)
    else $error("result appeared without a pipeline entry");

endmodule

### bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PIXELS = 1050;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 10;
  localparam int TIMEOUT_NS    = 40_000_000;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               pix_valid = 1'b0;
  logic                               pix_ready;
  lrc_pkg::pix_item_t                 pix = '0;
  logic                               res_valid;
  logic                               res_ready = 1'b0;
  lrc_pkg::res_item_t                 res;
  logic                               cfg_we = 1'b0;
  logic [lrc_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [lrc_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

  // Shadow copy of the block's registers and pixel storage
  logic [lrc_pkg::SIZE_BITS-1:0]         img_rows = 11'd64;
  logic [lrc_pkg::SIZE_BITS-1:0]         img_cols = 11'd64;
  logic [lrc_pkg::KERNEL_BITS-1:0]       kern [3] = '{default: '0};
  logic signed [lrc_pkg::PIXEL_BITS-1:0] upper_line [lrc_pkg::MAX_COLS];
  logic signed [lrc_pkg::PIXEL_BITS-1:0] lower_line [lrc_pkg::MAX_COLS];
  logic signed [lrc_pkg::PIXEL_BITS-1:0] win [3][3];
  int                                    row_pos = 0;
  int                                    col_pos = 0;

  lrc_pkg::res_item_t pending_sums [$];
  int        pixels_sent = 0;
  int        results_checked = 0;
  int        settings_applied = 0;
  int        mismatches = 0;
  bit        quiet_phase = 1'b0;
  // Set when the line width grows: entries past the old width were never
  // loaded, so the next request must start a frame.
  bit        restart_due = 1'b0;

  leftover_region_conv3x3_core dut (
    .clk,
    .rst,
    .pix_valid,
    .pix_ready,
    .pix,
    .res_valid,
    .res_ready,
    .res,
    .cfg_we,
    .cfg_index,
    .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Backstop against a hung handshake
  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Mostly back-to-back, some short pauses, a rare long one
  function automatic int pause_len();
    int pick;
    if (quiet_phase) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  function automatic int fit_size(input logic [lrc_pkg::SIZE_BITS-1:0] v, input int limit);
    if (v < 3) return 3;
    if (v > limit) return limit;
    return v;
  endfunction

  // 16-bit word biased toward the signed extremes
  function automatic logic signed [lrc_pkg::PIXEL_BITS-1:0] pick_word();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'sh8000;
    if (pick == 1) return 16'sh7fff;
    if (pick == 2) return 16'sd0;
    if (pick == 3) return -16'sd1;
    return lrc_pkg::PIXEL_BITS'($urandom());
  endfunction

  function automatic logic [lrc_pkg::KERNEL_BITS-1:0] pick_kernel();
    return {pick_word(), pick_word(), pick_word()};
  endfunction

  function automatic logic [lrc_pkg::SIZE_BITS-1:0] pick_size();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 2) return lrc_pkg::SIZE_BITS'($urandom_range(0, 2));
    if (pick < 4) return lrc_pkg::SIZE_BITS'($urandom_range(13, 24));
    return lrc_pkg::SIZE_BITS'($urandom_range(3, 12));
  endfunction

  // One pixel through the line stores and window; returns 1 with the
  // weighted sum when the centre lies in the leftover region.
  function automatic bit window_sum_step(input lrc_pkg::pix_item_t item,
                                         output lrc_pkg::res_item_t sum);
    int                                   nrows, ncols, r, c, first_row, first_col, pv, cv;
    logic [lrc_pkg::ACC_BITS-1:0]         acc;
    logic signed [lrc_pkg::COEF_BITS-1:0] coef;
    bit                                   hit;
    nrows = fit_size(img_rows, lrc_pkg::MAX_ROWS);
    ncols = fit_size(img_cols, lrc_pkg::MAX_COLS);
    sum = '0;
    hit = 1'b0;
    if (item.frame_start) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos % lrc_pkg::MAX_COLS;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = upper_line[c];
    win[1][2] = lower_line[c];
    win[2][2] = item.pixel;
    upper_line[c] = lower_line[c];
    lower_line[c] = item.pixel;

    // Region missed by the 4x4 block engine: rows below or columns right of it
    first_row = 1 + 4 * ((nrows - 2) / 4);
    first_col = 1 + 4 * ((ncols - 2) / 4);
    if (r >= 2 && c >= 2 && r < nrows && c < ncols &&
        (r - 1 >= first_row || c - 1 >= first_col)) begin
      acc = '0;
      for (int k = 0; k < 3; k++)
        for (int j = 0; j < 3; j++) begin
          coef = kern[k][lrc_pkg::COEF_BITS*j +: lrc_pkg::COEF_BITS];
          pv = win[k][j];
          cv = coef;
          acc = acc + pv * cv;
        end
      sum.centre_row = lrc_pkg::POS_BITS'(r - 1);
      sum.centre_col = lrc_pkg::POS_BITS'(c - 1);
      sum.conv_value = acc;
      hit = 1'b1;
    end

    // Raster advance; a position left beyond a shrunken size wraps here
    if (col_pos + 1 >= ncols) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= nrows) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    return hit;
  endfunction

  // Compare each delivered result with the oldest prediction
  task automatic check_result(input lrc_pkg::res_item_t got);
    lrc_pkg::res_item_t want;
    if (pending_sums.size() == 0) begin
      flag_mismatch($sformatf("unexpected result at (%0d,%0d) value %0d",
                              got.centre_row, got.centre_col, got.conv_value));
      return;
    end
    want = pending_sums.pop_front();
    results_checked++;
    if (got.centre_row !== want.centre_row)
      flag_mismatch($sformatf("centre_row got %0d want %0d", got.centre_row, want.centre_row));
    if (got.centre_col !== want.centre_col)
      flag_mismatch($sformatf("centre_col got %0d want %0d", got.centre_col, want.centre_col));
    if (got.conv_value !== want.conv_value)
      flag_mismatch($sformatf("conv_value at (%0d,%0d) got %0d want %0d", want.centre_row,
                              want.centre_col, got.conv_value, want.conv_value));
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) check_result(res);
  end

  // Result side back-pressure
  initial begin : res_stall
    int hold;
    forever begin
      @(posedge clk);
      res_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      hold = pause_len();
      if (hold > 0) begin
        res_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // Send one pixel request and predict its result at acceptance
  task automatic send_pixel(input logic signed [lrc_pkg::PIXEL_BITS-1:0] value,
                            input logic fs);
    lrc_pkg::pix_item_t item;
    lrc_pkg::res_item_t sum;
    int                 gap;
    gap = pause_len();
    if (restart_due) fs = 1'b1;
    restart_due = 1'b0;
    item.pixel = value;
    item.frame_start = fs;
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix <= item;
    @(posedge clk);
    while (!pix_ready) @(posedge clk);
    pixels_sent++;
    if (window_sum_step(item, sum)) pending_sums.push_back(sum);
  endtask

  // Drop valid, collect every outstanding result, let the pipeline empty
  task automatic wait_idle();
    int n;
    pix_valid <= 1'b0;
    n = 0;
    while (pending_sums.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (pending_sums.size() != 0) begin
      flag_mismatch($sformatf("%0d expected results never arrived", pending_sums.size()));
      pending_sums.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input lrc_pkg::cfg_index_t idx,
                           input logic [lrc_pkg::CFG_DATA_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      lrc_pkg::CFG_IMAGE_ROWS: img_rows = data[lrc_pkg::SIZE_BITS-1:0];
      lrc_pkg::CFG_IMAGE_COLS: begin
        if (fit_size(data[lrc_pkg::SIZE_BITS-1:0], lrc_pkg::MAX_COLS) >
            fit_size(img_cols, lrc_pkg::MAX_COLS))
          restart_due = 1'b1;
        img_cols = data[lrc_pkg::SIZE_BITS-1:0];
      end
      lrc_pkg::CFG_KERNEL_TOP:    kern[0] = data;
      lrc_pkg::CFG_KERNEL_MID:    kern[1] = data;
      lrc_pkg::CFG_KERNEL_BOTTOM: kern[2] = data;
      default: ;
    endcase
  endtask

  // Full register set; upper bits of the size words carry junk
  task automatic configure(input logic [lrc_pkg::SIZE_BITS-1:0] rows, cols,
                           input logic [lrc_pkg::KERNEL_BITS-1:0] top, mid, bottom);
    logic [63:0] junk;
    junk = {$urandom(), $urandom()};
    write_reg(lrc_pkg::CFG_IMAGE_ROWS,
              {junk[lrc_pkg::CFG_DATA_BITS-lrc_pkg::SIZE_BITS-1:0], rows});
    junk = {$urandom(), $urandom()};
    write_reg(lrc_pkg::CFG_IMAGE_COLS,
              {junk[lrc_pkg::CFG_DATA_BITS-lrc_pkg::SIZE_BITS-1:0], cols});
    write_reg(lrc_pkg::CFG_KERNEL_TOP, top);
    write_reg(lrc_pkg::CFG_KERNEL_MID, mid);
    write_reg(lrc_pkg::CFG_KERNEL_BOTTOM, bottom);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // Register values after reset: 64x64 frame and zero kernels; the third
  // line reaches the leftover columns at the right edge
  task automatic test_reset_defaults();
    repeat (3 * 64) send_pixel(pick_word(), 1'b0);
    wait_idle();
  endtask

  // Largest products and wrap of the sum; distinct coefficients to pin the
  // tap order; frame_start on two requests in a row hits the same column
  task automatic test_extreme_products();
    logic signed [lrc_pkg::PIXEL_BITS-1:0] seq [10] = '{16'sh8000, 16'sh7fff, -16'sd1,
                                                        16'sd1, 16'sd0, 16'sh7fff,
                                                        16'sh8000, 16'sd12345,
                                                        -16'sd2222, 16'sd7};
    configure(11'd3, 11'd3, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
    send_pixel(16'sh8000, 1'b1);
    repeat (8) send_pixel(16'sh8000, 1'b0);
    wait_idle();
    configure(11'd3, 11'd3, {16'sh7fff, -16'sd2, 16'sd1}, {-16'sd6, 16'sd5, -16'sd4},
              {16'sh8000, 16'sd8, -16'sd7});
    for (int i = 0; i < 10; i++) send_pixel(seq[i], i < 2);
    wait_idle();
  endtask

  // Out-of-range sizes clamp to 3 and to the maximum
  task automatic test_size_clamp();
    configure(11'h7ff, 11'd2, pick_kernel(), pick_kernel(), pick_kernel());
    send_pixel(pick_word(), 1'b1);
    repeat (40) send_pixel(pick_word(), 1'b0);
    wait_idle();
    configure(11'd1, 11'h7ff, pick_kernel(), pick_kernel(), pick_kernel());
    repeat (100) send_pixel(pick_word(), 1'b0);
    wait_idle();
    configure(11'd0, 11'd0, pick_kernel(), pick_kernel(), pick_kernel());
    repeat (12) send_pixel(pick_word(), 1'b0);
    wait_idle();
  endtask

  // Shrink the frame while the position is past the new limits
  task automatic test_resize_mid_frame();
    configure(11'd10, 11'd10, pick_kernel(), pick_kernel(), pick_kernel());
    send_pixel(pick_word(), 1'b1);
    repeat (56) send_pixel(pick_word(), 1'b0);
    wait_idle();
    configure(11'd7, 11'd6, pick_kernel(), pick_kernel(), pick_kernel());
    repeat (40) send_pixel(pick_word(), 1'b0);
    wait_idle();
    configure(11'd4, 11'd6, pick_kernel(), pick_kernel(), pick_kernel());
    repeat (30) send_pixel(pick_word(), 1'b0);
    wait_idle();
  endtask

  // Random sizes and kernels, whole frames with a rare stray frame_start
  task automatic test_random_frames();
    int                            first, count;
    logic [lrc_pkg::SIZE_BITS-1:0] rows, cols;
    first = pixels_sent;
    while (pixels_sent - first < RANDOM_PIXELS) begin
      rows = pick_size();
      cols = pick_size();
      quiet_phase = ($urandom_range(0, 3) == 0);
      configure(rows, cols, pick_kernel(), pick_kernel(), pick_kernel());
      count = fit_size(rows, lrc_pkg::MAX_ROWS) * fit_size(cols, lrc_pkg::MAX_COLS) *
              $urandom_range(1, 3) + $urandom_range(0, 9);
      if (count > 400) count = 400;
      send_pixel(pick_word(), $urandom_range(0, 4) != 0);
      repeat (count) send_pixel(pick_word(), $urandom_range(0, 49) == 0);
      wait_idle();
    end
    quiet_phase = 1'b0;
  endtask

  initial begin : run
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_extreme_products();
    test_size_clamp();
    test_resize_mid_frame();
    test_random_frames();
    wait_idle();
    $display("Sent %0d pixels over %0d register settings, checked %0d window sums",
             pixels_sent, settings_applied, results_checked);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

### leftover_region_conv3x3_core.f
design/lrc_pkg.sv
design/lrc_ram.sv
design/lrc_line_window.sv
design/lrc_mac.sv
design/leftover_region_conv3x3_core.sv
bench/testbench.sv
